// ----- hdl/epoch_seconds_to_civil_datetime_top_macros.svh -----
// Assertion macros shared by the epoch-to-civil converter RTL.
`ifndef EPOCH_SECONDS_TO_CIVIL_DATETIME_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATETIME_TOP_MACROS_SVH

// Same-cycle implication, off while in reset.
`define E2C_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, also checked in reset.
`define E2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/e2c_pkg.sv -----
// Types and constants of the epoch-to-civil converter.
package e2c_pkg;

  // register index, taken from paddr[2]
  localparam logic REG_UTC = 1'b0;
  localparam logic REG_DST = 1'b1;

  localparam longint unsigned SECS_PER_DAY  = 64'd86400;
  localparam longint unsigned SECS_PER_HOUR = 64'd3600;
  localparam longint unsigned DAYS_TO_ERA0  = 64'd719468;
  localparam longint unsigned ERA_DAYS      = 64'd146097;
  localparam longint unsigned YEARS_PER_ERA = 64'd400;

  // Bias of whole eras so every day count after the shift to March 1, year 0 is >= 0.
  localparam longint unsigned ERA_BIAS = 64'd6;
  localparam longint unsigned DAY_BIAS = DAYS_TO_ERA0 + ERA_DAYS * ERA_BIAS;
  localparam longint unsigned SEC_BIAS = SECS_PER_DAY * DAY_BIAS;
  localparam longint unsigned YEAR_BIAS = YEARS_PER_ERA * ERA_BIAS;

  // Reciprocal constants: m = ceil(2^s / d), exact over each operand's range.
  // seconds / 86400 = (seconds >> 7) / 675
  localparam longint unsigned DIV_DAY = 64'd675;
  localparam int              SH_DAY  = 41;
  localparam longint unsigned M_DAY   = ((64'd1 << SH_DAY) + DIV_DAY - 64'd1) / DIV_DAY;

  localparam int              SH_ERA  = 40;
  localparam longint unsigned M_ERA   = ((64'd1 << SH_ERA) + ERA_DAYS - 64'd1) / ERA_DAYS;

  localparam longint unsigned DIV_4Y  = 64'd1460;
  localparam int              SH_4Y   = 29;
  localparam longint unsigned M_4Y    = ((64'd1 << SH_4Y) + DIV_4Y - 64'd1) / DIV_4Y;

  localparam longint unsigned DIV_C   = 64'd36524;
  localparam int              SH_C    = 34;
  localparam longint unsigned M_C     = ((64'd1 << SH_C) + DIV_C - 64'd1) / DIV_C;

  localparam longint unsigned DIV_E   = 64'd146096;
  localparam int              SH_E    = 36;
  localparam longint unsigned M_E     = ((64'd1 << SH_E) + DIV_E - 64'd1) / DIV_E;

  localparam longint unsigned DIV_Y   = 64'd365;
  localparam int              SH_Y    = 27;
  localparam longint unsigned M_Y     = ((64'd1 << SH_Y) + DIV_Y - 64'd1) / DIV_Y;

  localparam longint unsigned DIV_100 = 64'd100;
  localparam int              SH_100  = 16;
  localparam longint unsigned M_100   = ((64'd1 << SH_100) + DIV_100 - 64'd1) / DIV_100;

  localparam longint unsigned DIV_MP  = 64'd153;
  localparam int              SH_MP   = 19;
  localparam longint unsigned M_MP    = ((64'd1 << SH_MP) + DIV_MP - 64'd1) / DIV_MP;

  localparam longint unsigned DIV_5   = 64'd5;
  localparam int              SH_5    = 14;
  localparam longint unsigned M_5     = ((64'd1 << SH_5) + DIV_5 - 64'd1) / DIV_5;

  localparam int              SH_HR   = 29;
  localparam longint unsigned M_HR    = ((64'd1 << SH_HR) + SECS_PER_HOUR - 64'd1) /
                                        SECS_PER_HOUR;

  localparam longint unsigned DIV_60  = 64'd60;
  localparam int              SH_MIN  = 18;
  localparam longint unsigned M_MIN   = ((64'd1 << SH_MIN) + DIV_60 - 64'd1) / DIV_60;

  // day split result: seconds of day, biased era, day of era
  typedef struct packed {
    logic [16:0] sod;
    logic [4:0]  era;
    logic [17:0] doe;
  } split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic signed [13:0] year;
    logic [3:0]         month;
    logic [4:0]         mday;
  } date_t;

endpackage

// ----- hdl/e2c_split.sv -----
// Stages 1-5: local seconds, floor split into days and seconds, era and day of era.
module e2c_split (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [37:0]  epoch,
  input  logic signed [16:0]  utc,
  input  logic signed [13:0]  dst,
  output logic                out_valid,
  output e2c_pkg::split_t     out
);

  logic [4:0]  vld;
  logic [39:0] sum;
  logic [38:0] u1;
  logic [63:0] pday2;
  logic [16:0] ulo2, ulo3, ulo4;
  logic [21:0] days3, days4;
  logic [16:0] pdsec4;
  logic [44:0] pera4;
  logic [4:0]  era_n;
  logic [21:0] doe_wide;

  // biased sum is always non-negative, so plain unsigned division below is floor
  assign sum = {{2{epoch[37]}}, epoch} + {{23{utc[16]}}, utc} + {{26{dst[13]}}, dst}
             + 40'(e2c_pkg::SEC_BIAS);

  assign era_n    = 5'(pera4 >> e2c_pkg::SH_ERA);
  assign doe_wide = days4 - 22'(era_n) * 22'(e2c_pkg::ERA_DAYS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1      <= sum[38:0];
      pday2   <= 64'(u1[38:7]) * 64'(e2c_pkg::M_DAY);
      ulo2    <= u1[16:0];
      days3   <= 22'(pday2 >> e2c_pkg::SH_DAY);
      ulo3    <= ulo2;
      pdsec4  <= 17'(days3) * 17'(e2c_pkg::SECS_PER_DAY);
      pera4   <= 45'(days3) * 45'(e2c_pkg::M_ERA);
      days4   <= days3;
      ulo4    <= ulo3;
      // remainder fits in 17 bits, so only the low product bits matter
      out.sod <= ulo4 - pdsec4;
      out.era <= era_n;
      out.doe <= doe_wide[17:0];
    end
  end

  assign out_valid = vld[4];

endmodule

// ----- hdl/e2c_tod.sv -----
// Stages 6-12: hour, minute and second of the day, delayed to match the date path.
module e2c_tod (
  input  logic            clk,
  input  logic            en,
  input  logic [16:0]     sod,
  output e2c_pkg::hms_t   out
);

  logic [34:0]    phour6;
  logic [16:0]    sod6;
  logic [4:0]     hour_n;
  logic [4:0]     hour7, hour8;
  logic [11:0]    hrem7, hrem8;
  logic [24:0]    pmin8;
  logic [5:0]     min_n;
  e2c_pkg::hms_t  hms9;
  e2c_pkg::hms_t  dly [3];

  assign hour_n = 5'(phour6 >> e2c_pkg::SH_HR);
  assign min_n  = 6'(pmin8 >> e2c_pkg::SH_MIN);

  always_ff @(posedge clk) begin
    if (en) begin
      phour6      <= 35'(sod) * 35'(e2c_pkg::M_HR);
      sod6        <= sod;
      hour7       <= hour_n;
      hrem7       <= 12'(sod6 - 17'(hour_n) * 17'(e2c_pkg::SECS_PER_HOUR));
      pmin8       <= 25'(hrem7) * 25'(e2c_pkg::M_MIN);
      hour8       <= hour7;
      hrem8       <= hrem7;
      hms9.hour   <= hour8;
      hms9.minute <= min_n;
      hms9.second <= 6'(hrem8 - 12'(min_n) * 12'(e2c_pkg::DIV_60));
      dly[0]      <= hms9;
      dly[1]      <= dly[0];
      dly[2]      <= dly[1];
    end
  end

  assign out = dly[2];

endmodule

// ----- hdl/e2c_civil.sv -----
// Stages 6-12: day of era to proleptic Gregorian year, month and day.
module e2c_civil (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [17:0]     doe,
  input  logic [4:0]      era,
  output logic            out_valid,
  output e2c_pkg::date_t  out
);

  logic [6:0]         vld;
  logic [37:0]        p4y6, pc6, pe6;
  logic [17:0]        doe6, doe7, doe8, doe9;
  logic [4:0]         era6, era7, era8;
  logic [17:0]        t7;
  logic [37:0]        py8;
  logic [8:0]         yoe_n;
  logic [8:0]         yoe9;
  logic signed [13:0] ybase9, ybase10, ybase11;
  logic [18:0]        p100;
  logic [1:0]         yq100;
  logic [17:0]        ydays;
  logic [17:0]        doy_wide;
  logic [8:0]         doy10, doy11;
  logic [10:0]        v5;
  logic [22:0]        pmp;
  logic [3:0]         mp11;
  logic [10:0]        w153;
  logic [22:0]        p5;
  logic [8:0]         q5;
  logic [8:0]         mday_wide;
  logic [3:0]         month_n;

  assign yoe_n = 9'(py8 >> e2c_pkg::SH_Y);

  assign p100     = 19'(yoe9) * 19'(e2c_pkg::M_100);
  assign yq100    = 2'(p100 >> e2c_pkg::SH_100);
  assign ydays    = 18'(yoe9) * 18'(e2c_pkg::DIV_Y) + 18'(yoe9 >> 2) - 18'(yq100);
  assign doy_wide = doe9 - ydays;

  // months counted from March
  assign v5  = 11'(doy10) * 11'(e2c_pkg::DIV_5) + 11'd2;
  assign pmp = 23'(v5) * 23'(e2c_pkg::M_MP);

  assign w153      = 11'(mp11) * 11'(e2c_pkg::DIV_MP) + 11'd2;
  assign p5        = 23'(w153) * 23'(e2c_pkg::M_5);
  assign q5        = 9'(p5 >> e2c_pkg::SH_5);
  assign mday_wide = doy11 - q5 + 9'd1;
  assign month_n   = (mp11 < 4'd10) ? mp11 + 4'd3 : mp11 - 4'd9;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4y6      <= 38'(doe) * 38'(e2c_pkg::M_4Y);
      pc6       <= 38'(doe) * 38'(e2c_pkg::M_C);
      pe6       <= 38'(doe) * 38'(e2c_pkg::M_E);
      doe6      <= doe;
      era6      <= era;
      t7        <= doe6 - 18'(p4y6 >> e2c_pkg::SH_4Y) + 18'(pc6 >> e2c_pkg::SH_C)
                 - 18'(pe6 >> e2c_pkg::SH_E);
      doe7      <= doe6;
      era7      <= era6;
      py8       <= 38'(t7) * 38'(e2c_pkg::M_Y);
      doe8      <= doe7;
      era8      <= era7;
      yoe9      <= yoe_n;
      ybase9    <= 14'(yoe_n) + 14'(era8) * 14'(e2c_pkg::YEARS_PER_ERA)
                 - 14'(e2c_pkg::YEAR_BIAS);
      doe9      <= doe8;
      doy10     <= doy_wide[8:0];
      ybase10   <= ybase9;
      mp11      <= 4'(pmp >> e2c_pkg::SH_MP);
      doy11     <= doy10;
      ybase11   <= ybase10;
      out.mday  <= mday_wide[4:0];
      out.month <= month_n;
      // January and February belong to the next year of a March-based year
      out.year  <= ybase11 + 14'(month_n <= 4'd2);
    end
  end

  assign out_valid = vld[6];

endmodule

// ----- hdl/epoch_seconds_to_civil_datetime_top.sv -----
// Converts signed Unix epoch seconds, shifted by the zone and daylight offsets,
// into a proleptic Gregorian year, month, day, hour, minute and second. The
// converter is a 12-stage pipeline of constant-reciprocal multiplies: it takes
// one timestamp every clock; a stall on the output freezes the whole pipeline,
// whose last stage is the output register. Offsets must be written over the
// register port only while no item is in flight; the block does not enforce this
// (byte address 0: zone offset, 4: daylight offset; paddr[1:0] is ignored).
module epoch_seconds_to_civil_datetime_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [37:0] epoch_seconds, [39:38] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  // [13:0] year, [17:14] month, [22:18] day_of_month, [27:23] hour,
  // [33:28] minute, [39:34] second
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "epoch_seconds_to_civil_datetime_top_macros.svh"

  logic signed [16:0] utc_offset_seconds;
  logic signed [13:0] daylight_offset_seconds;
  logic               en;
  logic               split_valid;
  e2c_pkg::split_t    split;
  e2c_pkg::hms_t      hms;
  e2c_pkg::date_t     date;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      utc_offset_seconds      <= '0;
      daylight_offset_seconds <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        e2c_pkg::REG_UTC: utc_offset_seconds      <= pwdata[16:0];
        e2c_pkg::REG_DST: daylight_offset_seconds <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      e2c_pkg::REG_UTC: prdata = {15'b0, utc_offset_seconds};
      e2c_pkg::REG_DST: prdata = {18'b0, daylight_offset_seconds};
      default:          prdata = '0;
    endcase
  end

  // pipeline moves unless a finished result is held back
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  e2c_split u_split (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .epoch     (s_tdata[37:0]),
    .utc       (utc_offset_seconds),
    .dst       (daylight_offset_seconds),
    .out_valid (split_valid),
    .out       (split)
  );

  e2c_tod u_tod (
    .clk (clk),
    .en  (en),
    .sod (split.sod),
    .out (hms)
  );

  e2c_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (split_valid),
    .doe       (split.doe),
    .era       (split.era),
    .out_valid (m_tvalid),
    .out       (date)
  );

  assign m_tdata = {hms.second, hms.minute, hms.hour, date.mday, date.month, date.year};

  `E2C_ASSERT_NEXT(a_rst_empty, rst, !m_tvalid, "output valid right after reset")
  `E2C_ASSERT_IMP(a_date_range, m_tvalid, date.month >= 4'd1 && date.month <= 4'd12 && date.mday >= 5'd1, "month or day out of range")
  `E2C_ASSERT_IMP(a_time_range, m_tvalid, hms.hour <= 5'd23 && hms.minute <= 6'd59 && hms.second <= 6'd59, "time of day out of range")
  `E2C_ASSERT_IMP(a_stall_hold, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

endmodule
